### rtl/mwg_pkg.sv
// Package for the multichannel waveform generator.
// Holds the sequencer state type, channel settings type and wave constants.
// No dependencies.
package mwg_pkg;

  // Item opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Wave type codes
  localparam logic [1:0] WAVE_SINE     = 2'd0;
  localparam logic [1:0] WAVE_SQUARE   = 2'd1;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd2;

  // Full-scale wave value in Q15 (+1.0)
  localparam logic signed [16:0] WAVE_ONE = 17'sd32768;

  // pi/2 in Q30, seed of the quarter-wave series
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Saturation limits of a sample
  localparam logic signed [18:0] SAMPLE_MAX = 19'sd32767;
  localparam logic signed [18:0] SAMPLE_MIN = -19'sd32768;

  // Per-channel sequencer steps
  typedef enum logic [2:0] {
    S_IDLE,
    S_MULP,   // tuning word times tick count
    S_ADDR,   // add phase offset
    S_ROM,    // quarter-wave table read
    S_WAVE,   // form the wave value
    S_MULA,   // amplitude times wave
    S_OUT     // round, add dc level, saturate
  } state_e;

  // Settings of one channel
  typedef struct packed {
    logic        [1:0]  wave_type;
    logic        [31:0] tuning_word;
    logic        [15:0] phase_offset;
    logic signed [15:0] amplitude;
    logic signed [15:0] dc_level;
  } chan_cfg_t;

endpackage

### rtl/multichannel_waveform_generator.sv
// Multichannel DDS waveform generator (sine, square, triangle) top level.
// Depends on mwg_pkg for the state type, settings struct and constants.
//
// A settings write (op 1) is stored at the edge that accepts it and leaves busy
// low. A tick (op 0) advances the tick counter and then runs every channel
// through one shared 32x32 multiplier under a small sequencer, channel by
// channel (phase multiply, offset add, table read, wave form, amplitude
// multiply, round and saturate); busy stays high until the last channel is
// done. Samples leave in channel order, one per valid_o pulse, and no new item
// is taken while busy is high; the last pulse of a tick carries last_o and may
// come in the same cycle as the acceptance of the next item. The receiver cannot
// stall: valid_o marks each sample for exactly one cycle. Channels at index 8
// and above cannot be written and produce zero samples.
module multichannel_waveform_generator #(
  parameter int NUM_CHANNELS   = 8,
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               op_i,
  input  logic [2:0]         channel_i,
  input  logic [1:0]         wave_type_i,
  input  logic [31:0]        tuning_word_i,
  input  logic [15:0]        phase_offset_i,
  input  logic signed [15:0] amplitude_i,
  input  logic signed [15:0] dc_level_i,
  output logic               valid_o,
  output logic [2:0]         out_channel_o,
  output logic signed [15:0] sample_o,
  output logic               last_o
);

  localparam int CH_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int NSTORE     = (NUM_CHANNELS < 8) ? NUM_CHANNELS : 8;
  localparam int ST_W       = (NSTORE > 1) ? $clog2(NSTORE) : 1;
  localparam int SINE_DEPTH = 1 << SINE_ADDR_BITS;

  // Quarter-wave table, built at elaboration from the Q30 series
  typedef logic [15:0] sine_rom_t [SINE_DEPTH];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t         rom;
    longint unsigned   x;
    longint unsigned   term;
    longint unsigned   odd;
    longint unsigned   r;
    longint            sum;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      odd  = 64'(2 * k + 1);
      x    = (mwg_pkg::HALF_PI_Q30 * odd) >> (SINE_ADDR_BITS + 1);
      term = x;
      sum  = longint'(x);
      term = (term * x) >> 30; term = (term * x) >> 30; term = term / 6;
      sum  = sum - longint'(term);
      term = (term * x) >> 30; term = (term * x) >> 30; term = term / 20;
      sum  = sum + longint'(term);
      term = (term * x) >> 30; term = (term * x) >> 30; term = term / 42;
      sum  = sum - longint'(term);
      term = (term * x) >> 30; term = (term * x) >> 30; term = term / 72;
      sum  = sum + longint'(term);
      term = (term * x) >> 30; term = (term * x) >> 30; term = term / 110;
      sum  = sum - longint'(term);
      term = (term * x) >> 30; term = (term * x) >> 30; term = term / 156;
      sum  = sum + longint'(term);
      if (sum < 0) begin
        sum = 0;
      end
      r = ((unsigned'(sum) * 64'd32768) + 64'd536870912) >> 30;
      if (r > 64'd32768) begin
        r = 64'd32768;
      end
      rom[k] = 16'(r);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Control state
  mwg_pkg::state_e    state_q, state_d;
  logic [CH_W-1:0]    ch_q, ch_d;
  logic [31:0]        tick_q, tick_d;
  mwg_pkg::chan_cfg_t cfg_q [NSTORE];
  logic               valid_q, valid_d;

  // Datapath registers
  mwg_pkg::chan_cfg_t        cur_q;
  logic [31:0]               prod_q;
  logic [31:0]               phase_q;
  logic [15:0]               rom_q;
  logic signed [16:0]        wave_q;
  logic [2:0]                out_ch_q;
  logic signed [15:0]        sample_q;
  logic                      last_q;

  // Combinational signals
  logic                      accept;
  logic                      cfg_we;
  logic                      ld_prod;
  logic                      ld_out;
  mwg_pkg::chan_cfg_t        sel_cfg;
  logic [31:0]               mul_a;
  logic [31:0]               mul_b;
  logic [31:0]               mul_p;
  logic [SINE_ADDR_BITS-1:0] rom_addr;
  logic signed [16:0]        sine_w;
  logic [31:0]               tri_d;
  logic signed [17:0]        tri_w;
  logic signed [16:0]        wave_w;
  logic signed [32:0]        rnd;
  logic signed [18:0]        sum_w;
  logic signed [15:0]        sat_w;

  assign accept = start && !busy;
  assign busy   = (state_q != mwg_pkg::S_IDLE);

  // Sequencer: next state and step enables
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    tick_d  = tick_q;
    cfg_we  = 1'b0;
    ld_prod = 1'b0;
    ld_out  = 1'b0;
    valid_d = 1'b0;
    unique case (state_q)
      mwg_pkg::S_IDLE: begin
        if (accept) begin
          if (op_i == mwg_pkg::OP_WRITE) begin
            cfg_we = 1'b1;
          end else begin
            tick_d  = tick_q + 32'd1;
            ch_d    = '0;
            state_d = mwg_pkg::S_MULP;
          end
        end
      end
      mwg_pkg::S_MULP: begin
        ld_prod = 1'b1;
        state_d = mwg_pkg::S_ADDR;
      end
      mwg_pkg::S_ADDR: state_d = mwg_pkg::S_ROM;
      mwg_pkg::S_ROM:  state_d = mwg_pkg::S_WAVE;
      mwg_pkg::S_WAVE: state_d = mwg_pkg::S_MULA;
      mwg_pkg::S_MULA: begin
        ld_prod = 1'b1;
        state_d = mwg_pkg::S_OUT;
      end
      mwg_pkg::S_OUT: begin
        ld_out  = 1'b1;
        valid_d = 1'b1;
        if (ch_q == CH_W'(NUM_CHANNELS - 1)) begin
          state_d = mwg_pkg::S_IDLE;
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = mwg_pkg::S_MULP;
        end
      end
      default: state_d = mwg_pkg::S_IDLE;
    endcase
  end

  // Control registers and settings store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mwg_pkg::S_IDLE;
      ch_q    <= '0;
      tick_q  <= '0;
      valid_q <= 1'b0;
      for (int i = 0; i < NSTORE; i++) begin
        cfg_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      tick_q  <= tick_d;
      valid_q <= valid_d;
      if (cfg_we && ({1'b0, channel_i} < 4'(NSTORE))) begin
        cfg_q[channel_i[ST_W-1:0]] <= '{wave_type:    wave_type_i,
                                        tuning_word:  tuning_word_i,
                                        phase_offset: phase_offset_i,
                                        amplitude:    amplitude_i,
                                        dc_level:     dc_level_i};
      end
    end
  end

  // Settings of the channel in work; unwritable channels read as zero
  always_comb begin
    sel_cfg = '0;
    if (ch_q < NSTORE) begin
      sel_cfg = cfg_q[ch_q[ST_W-1:0]];
    end
  end

  // Shared multiplier: phase step in S_MULP, amplitude scale in S_MULA
  always_comb begin
    if (state_q == mwg_pkg::S_MULA) begin
      mul_a = 32'(cur_q.amplitude);
      mul_b = 32'(wave_q);
    end else begin
      mul_a = sel_cfg.tuning_word;
      mul_b = tick_q;
    end
    mul_p = 32'(mul_a * mul_b);
  end

  // Table address, mirrored in quadrants 1 and 3
  always_comb begin
    rom_addr = phase_q[29 -: SINE_ADDR_BITS];
    if (phase_q[30]) begin
      rom_addr = ~rom_addr;
    end
  end

  // Wave value in Q15
  always_comb begin
    sine_w = signed'({1'b0, rom_q});
    if (phase_q[31]) begin
      sine_w = -sine_w;
    end
    tri_d = phase_q[31] ? (phase_q - 32'h8000_0000) : (32'h8000_0000 - phase_q);
    tri_w = signed'({1'b0, tri_d[31:15]}) - 18'sd32768;
    case (cur_q.wave_type)
      mwg_pkg::WAVE_SINE:     wave_w = sine_w;
      mwg_pkg::WAVE_SQUARE:   wave_w = ((phase_q != '0) && !phase_q[31]) ?
                                       mwg_pkg::WAVE_ONE : -mwg_pkg::WAVE_ONE;
      mwg_pkg::WAVE_TRIANGLE: wave_w = tri_w[16:0];
      default:                wave_w = '0;
    endcase
  end

  // Round half up at 2^15, add dc level, saturate
  always_comb begin
    rnd   = signed'({prod_q[31], prod_q}) + 33'sd16384;
    sum_w = 19'(cur_q.dc_level) + 19'(signed'(rnd[32:15]));
    if (sum_w > mwg_pkg::SAMPLE_MAX) begin
      sat_w = 16'sh7fff;
    end else if (sum_w < mwg_pkg::SAMPLE_MIN) begin
      sat_w = -16'sh8000;
    end else begin
      sat_w = sum_w[15:0];
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == mwg_pkg::S_MULP) begin
      cur_q <= sel_cfg;
    end
    if (ld_prod) begin
      prod_q <= mul_p;
    end
    if (state_q == mwg_pkg::S_ADDR) begin
      phase_q <= prod_q + {cur_q.phase_offset, 16'h0000};
    end
    if (state_q == mwg_pkg::S_ROM) begin
      rom_q <= SINE_ROM[rom_addr];
    end
    if (state_q == mwg_pkg::S_WAVE) begin
      wave_q <= wave_w;
    end
    if (ld_out) begin
      out_ch_q <= 3'(ch_q);
      sample_q <= sat_w;
      last_q   <= (ch_q == CH_W'(NUM_CHANNELS - 1));
    end
  end

  assign valid_o       = valid_q;
  assign out_channel_o = out_ch_q;
  assign sample_o      = sample_q;
  assign last_o        = last_q;

endmodule

### dv/multichannel_waveform_generator_checker.sv
// Checker for the multichannel waveform generator: watches the item and sample ports,
// keeps its own copy of the channel settings and tick count, and compares every sample.
// Depends on mwg_pkg for the opcode, wave codes, settings struct and constants.
module multichannel_waveform_generator_checker #(
  parameter int NUM_CHANNELS   = 8,
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               op_i,
  input  logic [2:0]         channel_i,
  input  logic [1:0]         wave_type_i,
  input  logic [31:0]        tuning_word_i,
  input  logic [15:0]        phase_offset_i,
  input  logic signed [15:0] amplitude_i,
  input  logic signed [15:0] dc_level_i,
  input  logic               valid_i,
  input  logic [2:0]         out_channel_i,
  input  logic signed [15:0] sample_i,
  input  logic               last_i,
  input  logic               end_check_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [2:0]         chan;
    logic signed [15:0] value;
    logic               last;
  } expected_sample_t;

  localparam int LUT_SIZE = 2 ** SINE_ADDR_BITS;

  int                 quarter_sine_lut [LUT_SIZE];
  mwg_pkg::chan_cfg_t chan_settings [NUM_CHANNELS];
  logic [31:0]        ticks_seen;
  expected_sample_t   pending_samples [$];
  int                 mismatches;
  bit                 drained;

  // Quarter-wave entry k: Taylor series of sin in Q30, up to x^13/13!
  function automatic int quarter_sine(int unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint unsigned r;
    longint          sum;
    x    = (mwg_pkg::HALF_PI_Q30 * longint'(2 * k + 1)) >> (SINE_ADDR_BITS + 1);
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (longint'(sum) * 32768 + (64'd1 << 29)) >> 30;
    if (r > 32768) r = 32768;
    return int'(r);
  endfunction

  // Wave value in Q15, +1.0 = WAVE_ONE
  function automatic int wave_of(logic [1:0] kind, logic [31:0] phase);
    int unsigned quad;
    int unsigned idx;
    logic [31:0] tri_dist;
    quad = phase[31:30];
    idx  = (phase >> (30 - SINE_ADDR_BITS)) & (LUT_SIZE - 1);
    case (kind)
      mwg_pkg::WAVE_SINE: begin
        // odd quadrants run the table backwards, the lower half is negated
        if (quad[0]) idx = LUT_SIZE - 1 - idx;
        return quad[1] ? -quarter_sine_lut[idx] : quarter_sine_lut[idx];
      end
      mwg_pkg::WAVE_SQUARE: begin
        // zero phase and half a turn both belong to the low level
        return (phase != 0 && !phase[31]) ? int'(mwg_pkg::WAVE_ONE)
                                          : -int'(mwg_pkg::WAVE_ONE);
      end
      mwg_pkg::WAVE_TRIANGLE: begin
        tri_dist = phase[31] ? phase - 32'h8000_0000 : 32'h8000_0000 - phase;
        return int'(tri_dist >> 15) - int'(mwg_pkg::WAVE_ONE);
      end
      default: return 0; // unused wave code: flat, sample is the dc level
    endcase
  endfunction

  // Scale by amplitude (round half up), add dc level, saturate
  function automatic logic signed [15:0] channel_sample(mwg_pkg::chan_cfg_t cfg,
                                                        logic [31:0] phase);
    longint prod;
    longint total;
    prod  = longint'($signed(cfg.amplitude)) * longint'(wave_of(cfg.wave_type, phase));
    total = longint'($signed(cfg.dc_level)) + ((prod + 16384) >>> 15);
    if (total > 32767) total = 32767;
    if (total < -32768) total = -32768;
    return total[15:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  initial begin
    for (int k = 0; k < LUT_SIZE; k++) quarter_sine_lut[k] = quarter_sine(k);
  end

  // Compare samples leaving the block, then predict the item taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    expected_sample_t want;
    logic [31:0]      phase;
    if (!rst_ni) begin
      ticks_seen = '0;
      foreach (chan_settings[i]) chan_settings[i] = '0;
      pending_samples.delete();
      mismatches = 0;
      drained = 1'b0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      // an unknown strobe counts as a sample too
      if (valid_i !== 1'b0) begin
        if (pending_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected sample ch %0d value %0d last %b",
                                    out_channel_i, sample_i, last_i));
        end else begin
          want = pending_samples.pop_front();
          if (out_channel_i !== want.chan)
            report_mismatch($sformatf("channel %0d, want %0d", out_channel_i, want.chan));
          if (sample_i !== want.value)
            report_mismatch($sformatf("ch %0d sample %0d, want %0d",
                                      want.chan, sample_i, want.value));
          if (last_i !== want.last)
            report_mismatch($sformatf("ch %0d last %b, want %b", want.chan, last_i, want.last));
        end
      end

      if (start_i && !busy_i) begin
        if (op_i == mwg_pkg::OP_WRITE) begin
          // with eight channels every 3-bit index exists; indexes of NUM_CHANNELS and above are dropped
          if (channel_i < NUM_CHANNELS)
            chan_settings[channel_i] = {wave_type_i, tuning_word_i, phase_offset_i,
                                        amplitude_i, dc_level_i};
        end else begin
          ticks_seen = ticks_seen + 32'd1;
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            phase = chan_settings[c].tuning_word * ticks_seen
                    + {chan_settings[c].phase_offset, 16'h0000};
            want.chan  = c[2:0];
            want.value = channel_sample(chan_settings[c], phase);
            want.last  = (c == NUM_CHANNELS - 1);
            pending_samples.push_back(want);
          end
        end
      end

      // whatever is still queued at the end never came out
      if (end_check_i && !drained) begin
        drained = 1'b1;
        foreach (pending_samples[i])
          report_mismatch($sformatf("missing sample ch %0d value %0d",
                                    pending_samples[i].chan, pending_samples[i].value));
      end

      pending_o <= pending_samples.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

### dv/multichannel_waveform_generator_test.sv
// Testbench top for the multichannel waveform generator: clock, reset, item stimulus
// (directed, then random in three idle settings) and the verdict.
// Depends on mwg_pkg, the block and multichannel_waveform_generator_checker.
module multichannel_waveform_generator_test;

  localparam int NUM_CHANNELS = 8;
  localparam int RANDOM_ITEMS = 300;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int SETTLE_CYCLES = 6 * NUM_CHANNELS + 12;
  localparam logic [1:0] WAVE_UNUSED = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               op_i = mwg_pkg::OP_TICK;
  logic [2:0]         channel_i = '0;
  logic [1:0]         wave_type_i = mwg_pkg::WAVE_SINE;
  logic [31:0]        tuning_word_i = '0;
  logic [15:0]        phase_offset_i = '0;
  logic signed [15:0] amplitude_i = '0;
  logic signed [15:0] dc_level_i = '0;
  logic               valid_o;
  logic [2:0]         out_channel_o;
  logic signed [15:0] sample_o;
  logic               last_o;
  logic               end_check = 1'b0;
  int                 fail_count;
  int                 samples_due;
  int                 idle_pct = 0;

  multichannel_waveform_generator #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) dut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .channel_i, .wave_type_i, .tuning_word_i,
    .phase_offset_i, .amplitude_i, .dc_level_i, .valid_o, .out_channel_o, .sample_o,
    .last_o
  );

  multichannel_waveform_generator_checker #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .op_i, .channel_i, .wave_type_i,
    .tuning_word_i, .phase_offset_i, .amplitude_i, .dc_level_i, .valid_i(valid_o),
    .out_channel_i(out_channel_o), .sample_i(sample_o), .last_i(last_o),
    .end_check_i(end_check), .fail_count_o(fail_count), .pending_o(samples_due)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // 16-bit value leaning toward the signed and unsigned extremes
  function automatic logic [15:0] pick16();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Tuning word: full range, single bits, slow and nearly wrapping steps
  function automatic logic [31:0] pick_tuning();
    case ($urandom_range(4))
      0: return 32'h1 << $urandom_range(31);
      1: return $urandom_range(4095);
      2: return 32'hFFFF_FFFF - $urandom_range(4095);
      default: return $urandom;
    endcase
  endfunction

  // Present one item after a random gap; returns at the edge that takes it
  task automatic send_item(input logic op, input logic [2:0] ch, input logic [1:0] wt,
                           input logic [31:0] tw, input logic [15:0] po,
                           input logic [15:0] amp, input logic [15:0] dc);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    op_i           <= op;
    channel_i      <= ch;
    wave_type_i    <= wt;
    tuning_word_i  <= tw;
    phase_offset_i <= po;
    amplitude_i    <= amp;
    dc_level_i     <= dc;
    do @(posedge clk_i); while (busy);
  endtask

  // Settings write of one channel
  task automatic write_chan(input logic [2:0] ch, input logic [1:0] wt,
                            input logic [31:0] tw, input logic [15:0] po,
                            input logic [15:0] amp, input logic [15:0] dc);
    send_item(mwg_pkg::OP_WRITE, ch, wt, tw, po, amp, dc);
  endtask

  // Ticks carry junk in the unused fields
  task automatic send_tick();
    send_item(mwg_pkg::OP_TICK, 3'($urandom), 2'($urandom), $urandom,
              16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int guard;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, then every wave, both saturation rails,
    // square and triangle at zero and half-turn phase, the unused wave code
    idle_pct = 26;
    send_tick();
    write_chan(3'd0, mwg_pkg::WAVE_SINE,     32'h0100_0000, 16'h0000, 16'h7FFF, 16'h0000);
    write_chan(3'd1, mwg_pkg::WAVE_SQUARE,   32'h8000_0000, 16'h0000, 16'h8000, 16'h0000);
    write_chan(3'd2, mwg_pkg::WAVE_TRIANGLE, 32'hFFFF_FFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF);
    write_chan(3'd3, WAVE_UNUSED,            32'h1234_5678, 16'h5555, 16'h3039, 16'h8000);
    write_chan(3'd4, mwg_pkg::WAVE_SINE,     32'h4000_0000, 16'h0000, 16'h8000, 16'h8000);
    write_chan(3'd5, mwg_pkg::WAVE_TRIANGLE, 32'h2000_0000, 16'h8000, 16'hFFFF, 16'h0001);
    write_chan(3'd6, mwg_pkg::WAVE_SQUARE,   32'h0000_0001, 16'h4000, 16'h7FFF, 16'hFFFF);
    write_chan(3'd7, mwg_pkg::WAVE_SINE,     32'h0000_0000, 16'hC000, 16'h0001, 16'h7FFF);
    repeat (5) send_tick();
    write_chan(3'd7, mwg_pkg::WAVE_TRIANGLE, 32'h8000_0000, 16'h0000, 16'h8000, 16'h0000);
    write_chan(3'd0, mwg_pkg::WAVE_SQUARE,   32'hFFFF_FFFF, 16'hFFFF, 16'h7FFF, 16'h8000);
    write_chan(3'd3, mwg_pkg::WAVE_SINE,     32'h0040_0000, 16'h2000, 16'h8000, 16'h7FFF);
    repeat (3) send_tick();

    // Random: sender idles 26%, then 62%, then never; hold off until drained between
    for (int phase_no = 0; phase_no < 3; phase_no++) begin
      idle_pct = (phase_no == 0) ? 26 : (phase_no == 1) ? 62 : 0;
      repeat (RANDOM_ITEMS / 3) begin
        if ($urandom_range(99) < 40)
          send_tick();
        else
          write_chan(3'($urandom_range(7)), 2'($urandom_range(3)), pick_tuning(),
                     pick16(), pick16(), pick16());
      end
      start <= 1'b0;
      do @(posedge clk_i); while (samples_due != 0);
    end

    // Drain, let any stray sample show up, then flag leftovers
    start <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk_i);
      guard++;
    end while (samples_due != 0 && guard < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    end_check <= 1'b1;
    repeat (3) @(posedge clk_i);

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/mwg_pkg.sv
rtl/multichannel_waveform_generator.sv
dv/multichannel_waveform_generator_checker.sv
dv/multichannel_waveform_generator_test.sv
